>>> rtl/lz11_pkg.sv
package lz11_pkg;

  localparam int unsigned WinDepth = 4096;
  localparam int unsigned WinAw    = $clog2(WinDepth);
  localparam int unsigned SizeW    = 24;
  localparam int unsigned CopyW    = 17;
  localparam int unsigned DistW    = WinAw + 1;
  localparam int unsigned InDepth  = 2;
  localparam int unsigned InAw     = $clog2(InDepth);
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutAw    = $clog2(OutDepth);

  localparam logic [2:0] ST_BYTE   = 3'd0;
  localparam logic [2:0] ST_NEED   = 3'd1;
  localparam logic [2:0] ST_ACCEPT = 3'd2;
  localparam logic [2:0] ST_REJECT = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam logic [2:0] PH_FLAG  = 3'd0;
  localparam logic [2:0] PH_TOKEN = 3'd1;
  localparam logic [2:0] PH_COPY  = 3'd2;

  localparam logic [3:0] SEL_LONG  = 4'h0;
  localparam logic [3:0] SEL_HUGE  = 4'h1;
  localparam logic [2:0] NEED_LONG  = 3'd3;
  localparam logic [2:0] NEED_HUGE  = 3'd4;
  localparam logic [2:0] NEED_SHORT = 3'd2;

  localparam logic [CopyW-1:0] LongBias = CopyW'(12'h011);
  localparam logic [CopyW-1:0] HugeBias = CopyW'(12'h111);
  localparam logic [3:0]       FlagBits = 4'd8;

  typedef struct packed {
    logic       pull;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;
  } result_t;

endpackage

>>> rtl/lz11_decompressor.sv
// LZ11 stream decoder with a queue interface on both sides.
// Input words carry op_i and data_byte_i and are taken when push is high and
// full is low. Op 0 feeds one compressed byte, op 1 asks for the next
// decompressed byte. Every input word yields exactly one result word, in
// order, holding out_byte_o, status_o and last_o; it waits on the result
// ports while empty is low and is taken when pop is high.
// The user must write the stream length through the configuration channel
// (cfg_valid_i, cfg_ready_o, out_size_i) only while idle; it is not enforced.
// A write restarts the stream but keeps the history window contents.
// An accepted word goes from the input queue into the decode stage, then
// through the window read stage into the result queue, whose head drives
// the result ports.
// Throughput, while the result queue has room, is one word per cycle, set by
// the single read port of the 4096-byte history window; a copy of distance
// one is served by forwarding. When the receiver stalls, the four-entry
// result queue fills and full rises; nothing is lost.
// Reset clears all control state and sets the stream length to zero, so
// every word answers finished until a length is written.
module lz11_decompressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  status_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [lz11_pkg::SizeW-1:0] out_size_i
);
  import lz11_pkg::*;

  logic           item_valid, item_take, res_valid;
  item_t          item;
  result_t        res, head;
  logic [OutAw:0] outq_count;

  assign cfg_ready_o = 1'b1;

  lz11_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .op_i         (op_i),
    .data_byte_i  (data_byte_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  lz11_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_size_i   (out_size_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .outq_count_i (outq_count),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  lz11_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .res_i   (res),
    .count_o (outq_count),
    .empty   (empty),
    .pop     (pop),
    .head_o  (head)
  );

  assign out_byte_o = head.out_byte;
  assign status_o   = head.status;
  assign last_o     = head.last;

endmodule

>>> rtl/lz11_front.sv
module lz11_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic            op_i,
  input  logic [7:0]      data_byte_i,
  output logic            item_valid_o,
  output lz11_pkg::item_t item_o,
  input  logic            item_take_i
);
  import lz11_pkg::*;

  item_t          slot_q [InDepth];
  logic [InAw-1:0] rptr_q, wptr_q;
  logic [InAw:0]   count_q;
  logic            wr_en, rd_en;

  assign full         = (count_q == (InAw+1)'(InDepth));
  assign item_valid_o = (count_q != '0);
  assign item_o       = slot_q[rptr_q];
  assign wr_en        = push && !full;
  assign rd_en        = item_take_i && item_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q  <= '0;
      wptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (wr_en) wptr_q <= wptr_q + 1'b1;
      if (rd_en) rptr_q <= rptr_q + 1'b1;
      count_q <= count_q + (InAw+1)'(wr_en) - (InAw+1)'(rd_en);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wptr_q].pull <= op_i;
      slot_q[wptr_q].data <= data_byte_i;
    end
  end

endmodule

>>> rtl/lz11_outq.sv
module lz11_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lz11_pkg::result_t res_i,
  output logic [lz11_pkg::OutAw:0] count_o,
  output logic              empty,
  input  logic              pop,
  output lz11_pkg::result_t head_o
);
  import lz11_pkg::*;

  result_t          slot_q [OutDepth];
  logic [OutAw-1:0] rptr_q, wptr_q;
  logic [OutAw:0]   count_q;
  logic             rd_en;

  assign count_o = count_q;
  assign empty   = (count_q == '0);
  assign head_o  = slot_q[rptr_q];
  assign rd_en   = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q  <= '0;
      wptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (rd_en) rptr_q <= rptr_q + 1'b1;
      count_q <= count_q + (OutAw+1)'(push_i) - (OutAw+1)'(rd_en);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= res_i;
  end

endmodule

>>> rtl/lz11_core.sv
module lz11_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [lz11_pkg::SizeW-1:0] cfg_size_i,
  input  logic              item_valid_i,
  input  lz11_pkg::item_t   item_i,
  output logic              item_take_o,
  input  logic [lz11_pkg::OutAw:0] outq_count_i,
  output logic              res_valid_o,
  output lz11_pkg::result_t res_o
);
  import lz11_pkg::*;

  logic [SizeW-1:0] out_size_q, out_count_q, out_count_d;
  logic [WinAw-1:0] write_pos_q, write_pos_d;
  logic [7:0]       flag_q, flag_d;
  logic [3:0]       bits_q, bits_d, bits_dec;
  logic [2:0]       phase_q, phase_d, have, need;
  logic [7:0]       tok0_q, tok0_d, tok1_q, tok1_d, tok2_q, tok2_d;
  logic [CopyW-1:0] copy_left_q, copy_left_d;
  logic [DistW-1:0] copy_dist_q, copy_dist_d;
  logic             lit_pend_q, lit_pend_d;
  logic [7:0]       lit_val_q, lit_val_d;

  logic             fire, done, emit, copy_rd, last, fwd;
  logic [2:0]       status;
  logic [7:0]       e_byte, b;
  logic [3:0]       sel;
  logic [WinAw-1:0] raddr;

  logic             w_valid_q, w_copy_q, w_zero_q, w_fwd_q, w_last_q;
  logic [2:0]       w_status_q;
  logic [7:0]       w_lit_q, fwd_val_q, rdata_q, w_value;
  logic [WinAw-1:0] w_waddr_q;
  logic             w_emit;

  logic [7:0]       window_q [WinDepth];

  assign fire        = item_valid_i && (({1'b0, outq_count_i} + (OutAw+2)'(w_valid_q))
                                        < (OutAw+2)'(OutDepth));
  assign item_take_o = fire;
  assign done        = (out_count_q >= out_size_q);
  assign b           = item_i.data;
  assign sel         = tok0_q[7:4];
  assign have        = phase_q - 3'd1;
  assign raddr       = write_pos_q - copy_dist_q[WinAw-1:0];
  assign bits_dec    = (bits_q != 4'd0) ? bits_q - 4'd1 : 4'd0;

  always_comb begin
    out_count_d = out_count_q;
    write_pos_d = write_pos_q;
    flag_d      = flag_q;
    bits_d      = bits_q;
    phase_d     = phase_q;
    tok0_d      = tok0_q;
    tok1_d      = tok1_q;
    tok2_d      = tok2_q;
    copy_left_d = copy_left_q;
    copy_dist_d = copy_dist_q;
    lit_pend_d  = lit_pend_q;
    lit_val_d   = lit_val_q;
    status      = ST_NEED;
    e_byte      = '0;
    copy_rd     = 1'b0;
    last        = 1'b0;
    need        = NEED_SHORT;
    if (sel == SEL_LONG) need = NEED_LONG;
    else if (sel == SEL_HUGE) need = NEED_HUGE;
    if (done) begin
      status = ST_DONE;
    end else if (!item_i.pull) begin
      if (lit_pend_q || copy_left_q != '0) begin
        status = ST_REJECT;
      end else begin
        status = ST_ACCEPT;
        if (phase_q == PH_FLAG) begin
          flag_d  = b;
          bits_d  = FlagBits;
          phase_d = PH_TOKEN;
        end else if (phase_q == PH_TOKEN && !flag_q[7]) begin
          lit_pend_d = 1'b1;
          lit_val_d  = b;
          flag_d     = {flag_q[6:0], 1'b0};
          bits_d     = bits_dec;
          phase_d    = (bits_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
        end else if (phase_q == PH_TOKEN) begin
          tok0_d  = b;
          phase_d = PH_COPY;
        end else if (have + 3'd1 >= need) begin
          if (sel == SEL_LONG) begin
            copy_left_d = CopyW'({tok0_q[3:0], tok1_q[7:4]}) + LongBias;
            copy_dist_d = DistW'({tok1_q[3:0], b}) + DistW'(1);
          end else if (sel == SEL_HUGE) begin
            copy_left_d = CopyW'({tok0_q[3:0], tok1_q, tok2_q[7:4]}) + HugeBias;
            copy_dist_d = DistW'({tok2_q[3:0], b}) + DistW'(1);
          end else begin
            copy_left_d = CopyW'(sel) + CopyW'(1);
            copy_dist_d = DistW'({tok0_q[3:0], b}) + DistW'(1);
          end
          flag_d  = {flag_q[6:0], 1'b0};
          bits_d  = bits_dec;
          phase_d = (bits_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
        end else begin
          if (have == 3'd1) tok1_d = b;
          else if (have == 3'd2) tok2_d = b;
          phase_d = phase_q + 3'd1;
        end
      end
    end else if (lit_pend_q) begin
      lit_pend_d = 1'b0;
      status     = ST_BYTE;
      e_byte     = lit_val_q;
    end else if (copy_left_q != '0) begin
      copy_left_d = copy_left_q - CopyW'(1);
      status      = ST_BYTE;
      copy_rd     = 1'b1;
    end
    if (status == ST_BYTE) begin
      write_pos_d = write_pos_q + 1'b1;
      out_count_d = out_count_q + SizeW'(1);
      if (out_count_d >= out_size_q) begin
        last        = 1'b1;
        copy_left_d = '0;
        lit_pend_d  = 1'b0;
      end
    end
  end

  assign emit   = (status == ST_BYTE);
  assign w_emit = w_valid_q && (w_status_q == ST_BYTE);
  assign fwd    = w_emit && (w_waddr_q == raddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_size_q  <= '0;
      out_count_q <= '0;
      write_pos_q <= '0;
      flag_q      <= '0;
      bits_q      <= '0;
      phase_q     <= PH_FLAG;
      tok0_q      <= '0;
      tok1_q      <= '0;
      tok2_q      <= '0;
      copy_left_q <= '0;
      copy_dist_q <= '0;
      lit_pend_q  <= 1'b0;
      lit_val_q   <= '0;
      w_valid_q   <= 1'b0;
    end else begin
      w_valid_q <= fire;
      if (cfg_we_i) begin
        out_size_q  <= cfg_size_i;
        out_count_q <= '0;
        write_pos_q <= '0;
        flag_q      <= '0;
        bits_q      <= '0;
        phase_q     <= PH_FLAG;
        tok0_q      <= '0;
        tok1_q      <= '0;
        tok2_q      <= '0;
        copy_left_q <= '0;
        copy_dist_q <= '0;
        lit_pend_q  <= 1'b0;
        lit_val_q   <= '0;
      end else if (fire) begin
        out_count_q <= out_count_d;
        write_pos_q <= write_pos_d;
        flag_q      <= flag_d;
        bits_q      <= bits_d;
        phase_q     <= phase_d;
        tok0_q      <= tok0_d;
        tok1_q      <= tok1_d;
        tok2_q      <= tok2_d;
        copy_left_q <= copy_left_d;
        copy_dist_q <= copy_dist_d;
        lit_pend_q  <= lit_pend_d;
        lit_val_q   <= lit_val_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      w_status_q <= status;
      w_last_q   <= last;
      w_lit_q    <= e_byte;
      w_copy_q   <= copy_rd;
      w_zero_q   <= (SizeW'(copy_dist_q) > out_count_q);
      w_fwd_q    <= fwd;
      w_waddr_q  <= write_pos_q;
      fwd_val_q  <= w_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_emit) window_q[w_waddr_q] <= w_value;
    if (fire && copy_rd) rdata_q <= window_q[raddr];
  end

  always_comb begin
    w_value = w_lit_q;
    if (w_copy_q) begin
      if (w_zero_q) w_value = '0;
      else if (w_fwd_q) w_value = fwd_val_q;
      else w_value = rdata_q;
    end
  end

  assign res_valid_o     = w_valid_q;
  assign res_o.out_byte  = w_value;
  assign res_o.status    = w_status_q;
  assign res_o.last      = w_last_q;

`ifndef NO_ASSERTIONS
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_count_q <= out_size_q) else $error("output count passed the stream size");
  a_one_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(lit_pend_q && copy_left_q != '0)) else $error("literal and copy pending together");
  a_emit_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && emit && !cfg_we_i |=> write_pos_q == $past(write_pos_q) + 1'b1)
    else $error("window position did not advance on an emitted word");
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= 3'd4 && bits_q <= FlagBits) else $error("parser state out of range");
`endif

endmodule

>>> dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lz11_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int RandomWords = 1700;
  localparam int SettleCycles = 8;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  logic             full;
  logic             op_i = 1'b0;
  logic [7:0]       data_byte_i = '0;
  logic             empty;
  logic             pop = 1'b0;
  logic [7:0]       out_byte_o;
  logic [2:0]       status_o;
  logic             last_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [SizeW-1:0] out_size_i = '0;

  lz11_decompressor dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .op_i       (op_i),
    .data_byte_i(data_byte_i),
    .empty      (empty),
    .pop        (pop),
    .out_byte_o (out_byte_o),
    .status_o   (status_o),
    .last_o     (last_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .out_size_i (out_size_i)
  );

  // Decoder state as the testbench sees it.
  logic [7:0]       hist_win [WinDepth];
  logic [WinAw-1:0] wr_pos;
  logic [SizeW-1:0] produced;
  logic [SizeW-1:0] stream_len;
  logic [7:0]       flags;
  logic [3:0]       flags_left;
  logic [2:0]       phase;
  logic [7:0]       tok [3];
  logic [CopyW-1:0] copy_len;
  logic [DistW-1:0] copy_dist;
  logic             lit_pend;
  logic [7:0]       lit_val;

  result_t awaited_words[$];
  int      errors = 0;
  int      cycles = 0;
  int      burst_left = 0;

  function automatic void restart_stream(logic [SizeW-1:0] len);
    stream_len = len;
    wr_pos = '0;
    produced = '0;
    flags = '0;
    flags_left = '0;
    phase = PH_FLAG;
    tok[0] = '0;
    tok[1] = '0;
    tok[2] = '0;
    copy_len = '0;
    copy_dist = '0;
    lit_pend = 1'b0;
    lit_val = '0;
  endfunction

  function automatic void store_byte(logic [7:0] v);
    hist_win[wr_pos] = v;
    wr_pos = wr_pos + 1'b1;
    produced = produced + 1'b1;
  endfunction

  function automatic void next_flag();
    flags = flags << 1;
    if (flags_left != 0) begin
      flags_left = flags_left - 1'b1;
    end
    phase = (flags_left == 0) ? PH_FLAG : PH_TOKEN;
  endfunction

  function automatic result_t decode_word(logic pull, logic [7:0] b);
    result_t    r;
    int         have;
    int         need;
    logic [3:0] sel;
    r = '0;
    if (produced >= stream_len) begin
      r.status = ST_DONE;
    end else if (!pull) begin
      if (lit_pend || copy_len != 0) begin
        r.status = ST_REJECT;
      end else begin
        r.status = ST_ACCEPT;
        if (phase == PH_FLAG) begin
          flags = b;
          flags_left = FlagBits;
          phase = PH_TOKEN;
        end else if (phase == PH_TOKEN) begin
          if (!flags[7]) begin
            lit_pend = 1'b1;
            lit_val = b;
            next_flag();
          end else begin
            tok[0] = b;
            phase = PH_COPY;
          end
        end else begin
          have = int'(phase) - 1;
          sel = tok[0][7:4];
          need = (sel == SEL_LONG) ? int'(NEED_LONG) :
                 (sel == SEL_HUGE) ? int'(NEED_HUGE) : int'(NEED_SHORT);
          if (have + 1 >= need) begin
            if (sel == SEL_LONG) begin
              copy_len = CopyW'({tok[0][3:0], tok[1][7:4]}) + LongBias;
              copy_dist = DistW'({tok[1][3:0], b}) + 1'b1;
            end else if (sel == SEL_HUGE) begin
              copy_len = CopyW'({tok[0][3:0], tok[1], tok[2][7:4]}) + HugeBias;
              copy_dist = DistW'({tok[2][3:0], b}) + 1'b1;
            end else begin
              copy_len = CopyW'(sel) + 1'b1;
              copy_dist = DistW'({tok[0][3:0], b}) + 1'b1;
            end
            next_flag();
          end else begin
            if (have < 3) begin
              tok[have] = b;
            end
            phase = phase + 1'b1;
          end
        end
      end
    end else if (lit_pend) begin
      lit_pend = 1'b0;
      r.out_byte = lit_val;
      store_byte(lit_val);
      r.status = ST_BYTE;
    end else if (copy_len != 0) begin
      if (SizeW'(copy_dist) <= produced) begin
        r.out_byte = hist_win[WinAw'(wr_pos - copy_dist[WinAw-1:0])];
      end
      copy_len = copy_len - 1'b1;
      store_byte(r.out_byte);
      r.status = ST_BYTE;
    end else begin
      r.status = ST_NEED;
    end
    if (r.status == ST_BYTE && produced >= stream_len) begin
      r.last = 1'b1;
      copy_len = '0;
      lit_pend = 1'b0;
    end
    return r;
  endfunction

  // Keeps every copy distance within the bytes already produced, so that
  // no never-written history entry is ever read.
  function automatic logic [7:0] legal_byte(logic [7:0] b);
    int         reach;
    int         hmax;
    int         have;
    logic [3:0] sel;
    logic [3:0] hi;
    reach = (produced > WinDepth) ? WinDepth : int'(produced);
    hmax = (reach == 0) ? 0 : (reach - 1) >> 8;
    if (phase == PH_FLAG) begin
      if (reach == 0) begin
        b[7] = 1'b0;
      end
    end else if (phase == PH_TOKEN) begin
      if (flags[7] && b[7:4] > SEL_HUGE && int'(b[3:0]) > hmax) begin
        b[3:0] = 4'($urandom_range(0, hmax));
      end
    end else begin
      have = int'(phase) - 1;
      sel = tok[0][7:4];
      if ((sel == SEL_LONG && have == 2) || (sel == SEL_HUGE && have == 3) ||
          (sel > SEL_HUGE && have == 1)) begin
        hi = (sel == SEL_LONG) ? tok[1][3:0] : (sel == SEL_HUGE) ? tok[2][3:0] : tok[0][3:0];
        if (int'(hi) == hmax && int'(b) > ((reach - 1) & 255)) begin
          b = 8'($urandom_range(0, (reach - 1) & 255));
        end
      end else if ((sel == SEL_LONG && have == 1) || (sel == SEL_HUGE && have == 2)) begin
        if (int'(b[3:0]) > hmax) begin
          b[3:0] = 4'($urandom_range(0, hmax));
        end
      end
    end
    return b;
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic send_word(logic pull, logic [7:0] b);
    push <= 1'b1;
    op_i <= pull;
    data_byte_i <= b;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
    awaited_words.push_back(decode_word(pull, b));
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (awaited_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_out_size(logic [SizeW-1:0] len);
    wait_idle();
    cfg_valid_i <= 1'b1;
    out_size_i <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    restart_stream(len);
  endtask

  // Receiver: pop follows a 32-bit pattern that is redrawn each time its index wraps.
  logic [31:0] stall_bits = '1;
  logic [4:0]  stall_idx = '0;
  result_t     want;

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (awaited_words.size() == 0) begin
        $error("result word arrived with none expected");
        errors = errors + 1;
      end else begin
        want = awaited_words.pop_front();
        if (out_byte_o !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_byte_o);
          errors = errors + 1;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors = errors + 1;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          errors = errors + 1;
        end
      end
    end
    if (stall_idx == 0) begin
      case ($urandom_range(0, 3))
        0, 1: stall_bits <= '1;
        2: stall_bits <= $urandom;
        default: stall_bits <= $urandom & $urandom;
      endcase
    end
    pop <= rst_ni && stall_bits[stall_idx];
    stall_idx <= stall_idx + 1'b1;
  end

  task automatic test_idle_after_reset();
    send_word(1'b0, 8'h5A);
    send_word(1'b1, 8'h00);
  endtask

  task automatic test_token_forms();
    write_out_size(SizeW'(10));
    send_word(1'b0, 8'h70);
    send_word(1'b1, 8'h00);
    send_word(1'b0, 8'hA5);
    send_word(1'b0, 8'h3C);
    send_word(1'b1, 8'hFF);
    send_word(1'b0, 8'h20);
    send_word(1'b0, 8'h00);
    repeat (3) send_word(1'b1, 8'h00);
    send_word(1'b0, 8'h10);
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'h03);
    repeat (7) send_word(1'b1, 8'hFF);
    send_word(1'b0, 8'hFF);
  endtask

  task automatic test_random_streams();
    int               active;
    int               budget;
    logic             pull;
    logic [SizeW-1:0] len;
    active = 0;
    while (active < RandomWords) begin
      case ($urandom_range(0, 5))
        0: len = SizeW'(1);
        1: len = '1;
        2: len = SizeW'($urandom_range(2, 40));
        3, 4: len = SizeW'($urandom_range(41, 600));
        default: len = SizeW'($urandom_range(601, 16777214));
      endcase
      write_out_size(len);
      budget = $urandom_range(40, 220);
      for (int n = 0; n < budget && produced < stream_len; n++) begin
        if (lit_pend || copy_len != 0) begin
          pull = ($urandom_range(0, 9) != 0);
        end else begin
          pull = ($urandom_range(0, 9) < 2);
        end
        send_word(pull, legal_byte(8'($urandom_range(0, 255))));
        active++;
      end
      if (produced >= stream_len) begin
        send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    restart_stream('0);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_after_reset();
    test_token_forms();
    test_random_streams();
    wait_idle();
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
